// ----- rtl/gdad_pkg.sv -----
// Shared types, constants and calendar helpers for the Gregorian date-add unit.
`timescale 1ns / 1ps
`default_nettype none

package gdad_pkg;

    localparam int DAY_W  = 5;
    localparam int MON_W  = 4;
    localparam int YEAR_W = 14;
    localparam int DUR_W  = 16;
    localparam int CEN_W  = 7;   // year modulo one hundred
    localparam int QUO_W  = 8;   // year divided by one hundred
    localparam int C4_W   = 2;   // centuries modulo four

    localparam int IN_TDATA_W  = 40;
    localparam int OUT_TDATA_W = 24;

    localparam logic [YEAR_W-1:0] YEAR_MAX = YEAR_W'(9999);
    localparam logic [MON_W-1:0]  MONTHS   = MON_W'(12);
    localparam logic [CEN_W-1:0]  CEN_LAST = CEN_W'(99);

    // Division of the year by one hundred: (y * 5243) >> 19 is exact for y < 16384.
    localparam int RECIP_100   = 5243;
    localparam int RECIP_SHIFT = 19;
    localparam int PROD_W      = 27;
    localparam int CENTURY     = 100;

    localparam logic [MON_W-1:0] MON_JAN = MON_W'(1);
    localparam logic [MON_W-1:0] MON_FEB = MON_W'(2);
    localparam logic [MON_W-1:0] MON_APR = MON_W'(4);
    localparam logic [MON_W-1:0] MON_JUN = MON_W'(6);
    localparam logic [MON_W-1:0] MON_SEP = MON_W'(9);
    localparam logic [MON_W-1:0] MON_NOV = MON_W'(11);

    localparam int QDEPTH = 2;
    localparam int QAW    = $clog2(QDEPTH);

    // One classified date waiting to be walked forward.
    typedef struct packed {
        logic [DAY_W-1:0]  day;
        logic [MON_W-1:0]  month;
        logic [YEAR_W-1:0] year;
        logic [DUR_W-1:0]  rem;
        logic [CEN_W-1:0]  y100;
        logic [C4_W-1:0]   c4;
        logic              bad;
    } t_job;

    function automatic logic is_leap(input logic [1:0] y_low, input logic [CEN_W-1:0] y100,
                                     input logic [C4_W-1:0] c4);
        is_leap = (y_low == 2'd0) && ((y100 != '0) || (c4 == '0));
    endfunction

    function automatic logic [DAY_W-1:0] month_len(input logic [MON_W-1:0] m,
                                                   input logic leap);
        case (m)
            MON_FEB: month_len = leap ? DAY_W'(29) : DAY_W'(28);
            MON_APR, MON_JUN, MON_SEP, MON_NOV: month_len = DAY_W'(30);
            default: month_len = DAY_W'(31);
        endcase
    endfunction

endpackage

`default_nettype wire

// ----- rtl/gdad_front.sv -----
// Front end: accepts a transaction, splits the year by century and checks the date.
`timescale 1ns / 1ps
`default_nettype none

module gdad_front (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_s_axis_tvalid,
    output logic                                    o_s_axis_tready,
    input  wire logic [gdad_pkg::IN_TDATA_W-1:0]    i_s_axis_tdata,
    output logic                                    o_push,
    output gdad_pkg::t_job                          o_job,
    input  wire logic                               i_full
);

    typedef enum logic [2:0] {
        F_IDLE = 3'b001,
        F_DIV  = 3'b010,
        F_CLS  = 3'b100
    } t_fstate;

    t_fstate r_state, n_state;

    logic [gdad_pkg::DAY_W-1:0]  r_day;
    logic [gdad_pkg::MON_W-1:0]  r_month;
    logic [gdad_pkg::YEAR_W-1:0] r_year;
    logic [gdad_pkg::DUR_W-1:0]  r_dur;
    logic [gdad_pkg::QUO_W-1:0]  r_quot;

    logic [gdad_pkg::PROD_W-1:0] w_prod;
    logic [gdad_pkg::CEN_W-1:0]  w_y100;
    logic                        w_leap;
    logic                        w_bad;

    assign o_s_axis_tready = (r_state == F_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= F_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_push  = 1'b0;
        case (r_state)
            F_IDLE: begin
                if (i_s_axis_tvalid) begin
                    n_state = F_DIV;
                end
            end
            F_DIV: begin
                n_state = F_CLS;
            end
            F_CLS: begin
                if (!i_full) begin
                    o_push  = 1'b1;
                    n_state = F_IDLE;
                end
            end
            default: begin
                n_state = F_IDLE;
            end
        endcase
    end

    assign w_prod = gdad_pkg::PROD_W'(r_year) * gdad_pkg::PROD_W'(gdad_pkg::RECIP_100);

    always_ff @(posedge i_clk) begin
        if (r_state == F_IDLE && i_s_axis_tvalid) begin
            r_day   <= i_s_axis_tdata[4:0];
            r_month <= i_s_axis_tdata[8:5];
            r_year  <= i_s_axis_tdata[22:9];
            r_dur   <= i_s_axis_tdata[38:23];
        end
        if (r_state == F_DIV) begin
            r_quot <= w_prod[gdad_pkg::RECIP_SHIFT +: gdad_pkg::QUO_W];
        end
    end

    assign w_y100 = gdad_pkg::CEN_W'(r_year - gdad_pkg::YEAR_W'(r_quot * gdad_pkg::CENTURY));
    assign w_leap = gdad_pkg::is_leap(r_year[1:0], w_y100, r_quot[1:0]);

    always_comb begin
        w_bad = (r_day == '0) || (r_month == '0) || (r_month > gdad_pkg::MONTHS) ||
                (r_year == '0) || (r_year > gdad_pkg::YEAR_MAX);
        if (!w_bad && (r_day > gdad_pkg::month_len(r_month, w_leap))) begin
            w_bad = 1'b1;
        end
    end

    always_comb begin
        o_job.day   = r_day;
        o_job.month = r_month;
        o_job.year  = r_year;
        o_job.rem   = (r_dur == '0) ? '0 : r_dur - gdad_pkg::DUR_W'(1);
        o_job.y100  = w_y100;
        o_job.c4    = r_quot[1:0];
        o_job.bad   = w_bad;
    end

endmodule

`default_nettype wire

// ----- rtl/gdad_queue.sv -----
// Short job queue between the classifying front end and the date walker.
`timescale 1ns / 1ps
`default_nettype none

module gdad_queue (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_push,
    input  wire gdad_pkg::t_job               i_job,
    output logic                              o_full,
    input  wire logic                         i_pop,
    output gdad_pkg::t_job                    o_job,
    output logic                              o_empty,
    output logic [gdad_pkg::QAW:0]            o_count
);

    gdad_pkg::t_job r_slot [gdad_pkg::QDEPTH];

    logic [gdad_pkg::QAW-1:0] r_wp;
    logic [gdad_pkg::QAW-1:0] r_rp;
    logic [gdad_pkg::QAW:0]   r_cnt;
    logic                     w_do_push;
    logic                     w_do_pop;

    assign o_full    = (r_cnt == (gdad_pkg::QAW+1)'(gdad_pkg::QDEPTH));
    assign o_empty   = (r_cnt == '0);
    assign o_count   = r_cnt;
    assign o_job     = r_slot[r_rp];
    assign w_do_push = i_push && !o_full;
    assign w_do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_do_push) begin
                r_wp <= r_wp + gdad_pkg::QAW'(1);
            end
            if (w_do_pop) begin
                r_rp <= r_rp + gdad_pkg::QAW'(1);
            end
            case ({w_do_push, w_do_pop})
                2'b10:   r_cnt <= r_cnt + (gdad_pkg::QAW+1)'(1);
                2'b01:   r_cnt <= r_cnt - (gdad_pkg::QAW+1)'(1);
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_do_push) begin
            r_slot[r_wp] <= i_job;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/gdad_back.sv -----
// Back end: walks a date forward one month per cycle and holds the result register.
`timescale 1ns / 1ps
`default_nettype none

module gdad_back (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire gdad_pkg::t_job                    i_job,
    input  wire logic                              i_empty,
    output logic                                   o_pop,
    output logic                                   o_m_axis_tvalid,
    input  wire logic                              i_m_axis_tready,
    output logic [gdad_pkg::OUT_TDATA_W-1:0]       o_m_axis_tdata,
    output logic                                   o_m_axis_tuser
);

    typedef enum logic [2:0] {
        B_IDLE = 3'b001,
        B_RUN  = 3'b010,
        B_DONE = 3'b100
    } t_bstate;

    t_bstate r_state, n_state;

    logic [gdad_pkg::DAY_W-1:0]  r_day,   n_day;
    logic [gdad_pkg::MON_W-1:0]  r_month, n_month;
    logic [gdad_pkg::YEAR_W-1:0] r_year,  n_year;
    logic [gdad_pkg::DUR_W-1:0]  r_rem,   n_rem;
    logic [gdad_pkg::CEN_W-1:0]  r_y100,  n_y100;
    logic [gdad_pkg::C4_W-1:0]   r_c4,    n_c4;
    logic                        r_bad,   n_bad;

    logic                        r_ovalid, n_ovalid;
    logic [gdad_pkg::DAY_W-1:0]  r_oday,   n_oday;
    logic [gdad_pkg::MON_W-1:0]  r_omonth, n_omonth;
    logic [gdad_pkg::YEAR_W-1:0] r_oyear,  n_oyear;
    logic                        r_obad,   n_obad;

    logic [gdad_pkg::DAY_W-1:0]  w_left;

    assign w_left = gdad_pkg::month_len(r_month, gdad_pkg::is_leap(r_year[1:0], r_y100, r_c4))
                    - r_day;

    always_comb begin
        n_state  = r_state;
        n_day    = r_day;
        n_month  = r_month;
        n_year   = r_year;
        n_rem    = r_rem;
        n_y100   = r_y100;
        n_c4     = r_c4;
        n_bad    = r_bad;
        n_ovalid = r_ovalid;
        n_oday   = r_oday;
        n_omonth = r_omonth;
        n_oyear  = r_oyear;
        n_obad   = r_obad;
        o_pop    = 1'b0;

        if (r_ovalid && i_m_axis_tready) begin
            n_ovalid = 1'b0;
        end

        case (r_state)
            B_IDLE: begin
                if (!i_empty) begin
                    o_pop   = 1'b1;
                    n_day   = i_job.day;
                    n_month = i_job.month;
                    n_year  = i_job.year;
                    n_rem   = i_job.rem;
                    n_y100  = i_job.y100;
                    n_c4    = i_job.c4;
                    n_bad   = i_job.bad;
                    n_state = i_job.bad ? B_DONE : B_RUN;
                end
            end
            B_RUN: begin
                if (r_rem <= gdad_pkg::DUR_W'(w_left)) begin
                    // The rest of the run ends inside the current month.
                    n_day   = r_day + r_rem[gdad_pkg::DAY_W-1:0];
                    n_rem   = '0;
                    n_state = B_DONE;
                end else begin
                    n_rem = r_rem - gdad_pkg::DUR_W'(w_left) - gdad_pkg::DUR_W'(1);
                    n_day = gdad_pkg::DAY_W'(1);
                    if (r_month == gdad_pkg::MONTHS) begin
                        n_month = gdad_pkg::MON_JAN;
                        n_year  = r_year + gdad_pkg::YEAR_W'(1);
                        if (r_y100 == gdad_pkg::CEN_LAST) begin
                            n_y100 = '0;
                            n_c4   = r_c4 + gdad_pkg::C4_W'(1);
                        end else begin
                            n_y100 = r_y100 + gdad_pkg::CEN_W'(1);
                        end
                    end else begin
                        n_month = r_month + gdad_pkg::MON_W'(1);
                    end
                end
            end
            B_DONE: begin
                if (!r_ovalid || i_m_axis_tready) begin
                    n_ovalid = 1'b1;
                    n_oday   = r_bad ? '0 : r_day;
                    n_omonth = r_bad ? '0 : r_month;
                    n_oyear  = r_bad ? '0 : r_year;
                    n_obad   = r_bad;
                    n_state  = B_IDLE;
                end
            end
            default: begin
                n_state = B_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= B_IDLE;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_ovalid <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_day    <= n_day;
        r_month  <= n_month;
        r_year   <= n_year;
        r_rem    <= n_rem;
        r_y100   <= n_y100;
        r_c4     <= n_c4;
        r_bad    <= n_bad;
        r_oday   <= n_oday;
        r_omonth <= n_omonth;
        r_oyear  <= n_oyear;
        r_obad   <= n_obad;
    end

    assign o_m_axis_tvalid = r_ovalid;
    assign o_m_axis_tdata  = {1'b0, r_oyear, r_omonth, r_oday};
    assign o_m_axis_tuser  = r_obad;

endmodule

`default_nettype wire

// ----- rtl/gregorian_date_add_days_unit.sv -----
// Top level of the Gregorian date-add unit: front end, job queue and date walker.
`timescale 1ns / 1ps
`default_nettype none

// This unit takes a start date and an event length in days and returns the
// inclusive last day of the event, start plus duration minus one, following
// the Gregorian leap-year rules (every fourth year, except centuries that are
// not a multiple of four hundred). A duration of zero is treated as one day.
// A start date with day zero, a month outside 1 to 12, a year outside 1 to
// 9999 or a day past the end of its month is flagged on tuser, and the date
// fields of that result read zero. One result transaction comes out for each
// input transaction, in order. The front end handles each date in turn:
// capture, a reciprocal multiply that splits the year into centuries, and
// the validity check. It takes the next transaction once the last is queued.
// The back end then walks the date forward one month per cycle, skipping the
// walk for an invalid date. A two-entry queue between the two halves lets
// the front end check the next date while the back end walks the current one,
// and the output register lets the back end start a new date while a result
// waits.
module gregorian_date_add_days_unit (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // Input transaction. tdata from bit 0: start_day[4:0], start_month[8:5],
    // start_year[22:9], duration_days[38:23], zero fill [39].
    input  wire logic        i_s_axis_tvalid,
    output logic             o_s_axis_tready,
    input  wire logic [39:0] i_s_axis_tdata,
    // Result transaction. tdata from bit 0: end_day[4:0], end_month[8:5],
    // end_year[22:9], zero fill [23]. tuser: date_invalid.
    output logic             o_m_axis_tvalid,
    input  wire logic        i_m_axis_tready,
    output logic [23:0]      o_m_axis_tdata,
    output logic             o_m_axis_tuser
);

    gdad_pkg::t_job             w_push_job;
    gdad_pkg::t_job             w_pop_job;
    logic                       w_push;
    logic                       w_full;
    logic                       w_pop;
    logic                       w_empty;
    logic [gdad_pkg::QAW:0]     w_count;

    // Captures the transaction and classifies it as valid or invalid.
    gdad_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .o_push          (w_push),
        .o_job           (w_push_job),
        .i_full          (w_full)
    );

    gdad_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_job   (w_push_job),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_job   (w_pop_job),
        .o_empty (w_empty),
        .o_count (w_count)
    );

    // Walks each valid date forward month by month and registers the result.
    gdad_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_job           (w_pop_job),
        .i_empty         (w_empty),
        .o_pop           (w_pop),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser)
    );

`ifndef SYNTHESIS
    // The front end never pushes into a full queue.
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_push && w_full))
        else $error("job queue overflow");

    // The back end never pops an empty queue.
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_pop && w_empty))
        else $error("job queue underflow");

    // A flagged result carries an all-zero date.
    a_invalid_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && o_m_axis_tuser) |-> (o_m_axis_tdata == '0))
        else $error("invalid result with nonzero date");

    // A good result has a real day and month.
    a_valid_date: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && !o_m_axis_tuser) |->
            ((o_m_axis_tdata[4:0] != 5'd0) && (o_m_axis_tdata[8:5] != 4'd0) &&
             (o_m_axis_tdata[8:5] <= gdad_pkg::MONTHS) && (o_m_axis_tdata[4:0] <= 5'd31)))
        else $error("result date out of calendar range");

    // The queue fill count never exceeds its depth.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_count <= (gdad_pkg::QAW+1)'(gdad_pkg::QDEPTH))
        else $error("job queue count out of range");
`endif

endmodule

`default_nettype wire
